// ----- src/hsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and arithmetic helpers of the sensor frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfd_pkg;

    // crc-8 of the sensor words: poly 0x31, init 0xff, msb first
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // byte positions inside the six-byte reply that carry a crc
    localparam logic [2:0] POS_CRC_A = 3'd2;
    localparam logic [2:0] POS_CRC_B = 3'd5;

    // frame kinds
    localparam logic KIND_MEAS = 1'b0;
    localparam logic KIND_ID   = 1'b1;

    // conversion scales, in hundredths
    localparam logic [14:0] SCALE_C = 15'd17500;
    localparam logic [14:0] SCALE_F = 15'd31500;
    localparam logic [13:0] SCALE_H = 14'd10000;

    // offsets; kelvin = qc - 4500 + 27315 = qc + 22815
    localparam logic [14:0] OFFS_C     = 15'd4500;
    localparam logic [15:0] OFFS_F     = 16'd4900;
    localparam logic [15:0] OFFS_K     = 16'd22815;
    localparam logic [15:0] KELVIN_MAX = 16'd30815;

    localparam logic [16:0] DIVISOR = 17'd65535;

    localparam int QUEUE_DEPTH_DEF = 2;

    // one decoded frame handed from the front to the back
    typedef struct packed {
        logic        err;
        logic        kind;
        logic [31:0] data;
    } t_frame;

    // one result item
    typedef struct packed {
        logic               status;
        logic [15:0]        raw_temperature;
        logic [15:0]        raw_humidity;
        logic signed [14:0] celsius_centi;
        logic signed [15:0] fahrenheit_centi;
        logic [14:0]        kelvin_centi;
        logic [13:0]        humidity_centi;
        logic [31:0]        chip_id;
    } t_result;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x < 2^31: x = q*65536 + r  ->  x = q*65535 + (r + q)
    // and r + q stays below twice the divisor, so one correction step is enough
    function automatic logic [15:0] div_65535(input logic [30:0] x);
        logic [14:0] q;
        logic [16:0] rem;
        q   = x[30:16];
        rem = {1'b0, x[15:0]} + {2'b00, q};
        return {1'b0, q} + {15'd0, (rem >= DIVISOR)};
    endfunction

endpackage

`default_nettype wire

// ----- src/hsfd_front.sv -----
// ----------------------------------------------------------------------------
// hsfd_front
// Byte parser: tracks the position in the reply, runs the crc per word and
// hands each completed frame to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_front
    import hsfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_start,
    input  wire logic       i_kind,
    input  wire logic       i_q_ready,
    output logic            o_q_valid,
    output t_frame          o_q_frame
);

    logic [2:0]  r_pos;
    logic [7:0]  r_crc;
    logic [31:0] r_data;
    logic        r_ok;

    logic [2:0]  n_pos;
    logic [7:0]  n_crc;
    logic [31:0] n_data;
    logic        n_ok;

    logic [2:0]  pos;
    logic [7:0]  crc;
    logic        accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && o_ready;

    // start or a wrapped position begins a fresh frame
    assign pos = (i_start || r_pos > POS_CRC_B) ? 3'd0 : r_pos;
    assign crc = (i_start || r_pos > POS_CRC_B) ? CRC_INIT : r_crc;

    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_data = r_data;
        n_ok   = r_ok;
        o_q_valid      = 1'b0;
        o_q_frame.err  = !(r_ok && (crc == i_byte));
        o_q_frame.kind = i_kind;
        o_q_frame.data = r_data;
        if (accept) begin
            unique case (pos)
                POS_CRC_A: begin
                    n_ok  = (crc == i_byte);
                    n_crc = CRC_INIT;
                    n_pos = pos + 3'd1;
                end
                POS_CRC_B: begin
                    n_crc     = CRC_INIT;
                    n_pos     = 3'd0;
                    o_q_valid = 1'b1;
                end
                default: begin
                    n_crc  = crc_byte(crc, i_byte);
                    n_data = {r_data[23:0], i_byte};
                    n_pos  = pos + 3'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 3'd0;
            r_crc  <= CRC_INIT;
            r_data <= 32'd0;
            r_ok   <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_data <= n_data;
            r_ok   <= n_ok;
        end
    end

endmodule

`default_nettype wire

// ----- src/hsfd_queue.sv -----
// ----------------------------------------------------------------------------
// hsfd_queue
// Small fifo of decoded frames between the parser and the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_queue
    import hsfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  t_frame    i_wr_frame,
    output logic      o_rd_valid,
    input  wire logic i_rd_ready,
    output t_frame    o_rd_frame
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic push;
    logic pop;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_frame = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/hsfd_back.sv -----
// ----------------------------------------------------------------------------
// hsfd_back
// Conversion pipeline: scale multiply, divide by 65535, offsets and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_back
    import hsfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_frame    i_frame,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_result
);

    // stage 1: products
    logic        r_s1_v;
    t_frame      r_s1_f;
    logic [30:0] r_s1_pc;
    logic [30:0] r_s1_pf;
    logic [29:0] r_s1_ph;

    // stage 2: quotients
    logic        r_s2_v;
    t_frame      r_s2_f;
    logic [14:0] r_s2_qc;
    logic [14:0] r_s2_qf;
    logic [13:0] r_s2_qh;

    logic        r_out_v;
    t_result     r_out;

    logic        out_ready;
    logic        s2_ready;
    logic        s1_ready;
    logic [15:0] n_qc;
    logic [15:0] n_qf;
    logic [15:0] n_qh;
    logic [15:0] kel_sum;
    t_result     n_out;

    assign out_ready = !r_out_v || i_ready;
    assign s2_ready  = !r_s2_v || out_ready;
    assign s1_ready  = !r_s1_v || s2_ready;
    assign o_ready   = s1_ready;
    assign o_valid   = r_out_v;
    assign o_result  = r_out;

    assign n_qc = div_65535(r_s1_pc);
    assign n_qf = div_65535(r_s1_pf);
    assign n_qh = div_65535({1'b0, r_s1_ph});

    assign kel_sum = {1'b0, r_s2_qc} + OFFS_K;

    always_comb begin
        n_out = '0;
        n_out.status = r_s2_f.err;
        if (!r_s2_f.err) begin
            n_out.raw_temperature = r_s2_f.data[31:16];
            n_out.raw_humidity    = r_s2_f.data[15:0];
            if (r_s2_f.kind == KIND_ID) begin
                n_out.chip_id = r_s2_f.data;
            end else begin
                // results lie in range, so the wrapped differences are exact
                n_out.celsius_centi    = r_s2_qc - OFFS_C;
                n_out.fahrenheit_centi = {1'b0, r_s2_qf} - OFFS_F;
                n_out.kelvin_centi     = (kel_sum > KELVIN_MAX) ? KELVIN_MAX[14:0]
                                                                : kel_sum[14:0];
                n_out.humidity_centi   = r_s2_qh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_f  <= i_frame;
            r_s1_pc <= 31'(i_frame.data[31:16]) * 31'(SCALE_C);
            r_s1_pf <= 31'(i_frame.data[31:16]) * 31'(SCALE_F);
            r_s1_ph <= 30'(i_frame.data[15:0]) * 30'(SCALE_H);
        end
        if (s2_ready) begin
            r_s2_f  <= r_s1_f;
            r_s2_qc <= n_qc[14:0];
            r_s2_qf <= n_qf[14:0];
            r_s2_qh <= n_qh[13:0];
        end
        if (out_ready) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= i_valid;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
            if (out_ready) begin
                r_out_v <= r_s2_v;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/humidity_sensor_frame_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_unit
// Decodes six-byte sensor replies (two crc-checked words) into measurement
// or chip identification results.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the queue has room, one result per six bytes
// path: after its sixth byte beat, a frame passes through these registers
//   (queue, multiply stage, divide stage, output register)
// reset: synchronous, active low; clears byte position, crc, frame kind,
//   queue and pipeline valids
`default_nettype none

module humidity_sensor_frame_decoder_unit
    import hsfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  wire logic         i_s_tuser,   // [0] frame_start
    // output stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [15:0] raw_temperature, [31:16] raw_humidity, [46:32] celsius_centi,
    // [62:47] fahrenheit_centi, [77:63] kelvin_centi, [91:78] humidity_centi,
    // [123:92] chip_id, [127:124] zero
    output logic [127:0]      o_m_tdata,
    output logic              o_m_tuser,   // [0] status
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic    r_frame_kind;

    logic    q_wr_valid;
    logic    q_wr_ready;
    t_frame  q_wr_frame;
    logic    q_rd_valid;
    logic    q_rd_ready;
    t_frame  q_rd_frame;
    t_result result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_frame_kind} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_kind <= KIND_MEAS;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_frame_kind <= pwdata[0];
        end
    end

    hsfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_start   (i_s_tuser),
        .i_kind    (r_frame_kind),
        .i_q_ready (q_wr_ready),
        .o_q_valid (q_wr_valid),
        .o_q_frame (q_wr_frame)
    );

    hsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (q_wr_valid),
        .o_wr_ready (q_wr_ready),
        .i_wr_frame (q_wr_frame),
        .o_rd_valid (q_rd_valid),
        .i_rd_ready (q_rd_ready),
        .o_rd_frame (q_rd_frame)
    );

    hsfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_rd_valid),
        .o_ready  (q_rd_ready),
        .i_frame  (q_rd_frame),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    assign o_m_tuser = result.status;
    assign o_m_tdata = {4'd0,
                        result.chip_id,
                        result.humidity_centi,
                        result.kelvin_centi,
                        result.fahrenheit_centi,
                        result.celsius_centi,
                        result.raw_humidity,
                        result.raw_temperature};

endmodule

`default_nettype wire
